// ===== rtl/nsca_pkg.sv =====
// ----------------------------------------------------------------------------
// nsca_pkg
// Shared widths, command codes and structs for the nearest station
// capacity assignment block.
// ----------------------------------------------------------------------------
package nsca_pkg;

	// table geometry
	localparam int SLOT_W       = 6;
	localparam int MAX_STATIONS = 2 ** SLOT_W;
	localparam int CNT_W        = SLOT_W + 1;

	// field and arithmetic widths
	localparam int DATA_W = 16;
	localparam int SQ_W   = 2 * DATA_W;
	localparam int DIST_W = SQ_W + 1;

	// command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_ASSIGN = 1'b1;

	// one station table entry (load counter is kept apart)
	typedef struct packed {
		logic [DATA_W-1:0]        ident;
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic [DATA_W-1:0]        rng;
		logic [DATA_W-1:0]        lim;
	} station_t;

	// sweep tag that rides along with each table read
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [SLOT_W-1:0] slot;
	} tag_t;

	// candidate leaving the distance unit
	typedef struct packed {
		logic              valid;
		logic              last;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [DIST_W-1:0] sq_dist;
	} cand_t;

endpackage

// ===== rtl/nsca_station_mem.sv =====
// ----------------------------------------------------------------------------
// nsca_station_mem
// Station table: entry array plus a separate load counter array, each with
// one write port and one registered read port on a shared address.
// ----------------------------------------------------------------------------
module nsca_station_mem (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [nsca_pkg::SLOT_W-1:0]  wr_addr,
	input  nsca_pkg::station_t           wr_ent,
	input  logic                         ld_wr_en,
	input  logic [nsca_pkg::SLOT_W-1:0]  ld_wr_addr,
	input  logic [nsca_pkg::DATA_W-1:0]  ld_wr_data,
	input  logic [nsca_pkg::SLOT_W-1:0]  rd_addr,
	output nsca_pkg::station_t           rd_ent,
	output logic [nsca_pkg::DATA_W-1:0]  rd_load
);

	nsca_pkg::station_t          ent_mem  [nsca_pkg::MAX_STATIONS];
	logic [nsca_pkg::DATA_W-1:0] load_mem [nsca_pkg::MAX_STATIONS];

	nsca_pkg::station_t          rd_ent_q;
	logic [nsca_pkg::DATA_W-1:0] rd_load_q;

	// entry array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[wr_addr] <= wr_ent;
		end
		rd_ent_q <= ent_mem[rd_addr];
	end

	// load counters
	always_ff @(posedge clk) begin
		if (ld_wr_en) begin
			load_mem[ld_wr_addr] <= ld_wr_data;
		end
		rd_load_q <= load_mem[rd_addr];
	end

	assign rd_ent  = rd_ent_q;
	assign rd_load = rd_load_q;

endmodule

// ===== rtl/nsca_dist_unit.sv =====
// ----------------------------------------------------------------------------
// nsca_dist_unit
// Pipelined squared distance and eligibility unit, shared by every slot of
// a sweep: abs difference, squares, then sum and range compare.
// ----------------------------------------------------------------------------
module nsca_dist_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nsca_pkg::tag_t                     tag_s1,
	input  nsca_pkg::station_t                 ent_s1,
	input  logic [nsca_pkg::DATA_W-1:0]        load_s1,
	input  logic signed [nsca_pkg::DATA_W-1:0] node_x,
	input  logic signed [nsca_pkg::DATA_W-1:0] node_y,
	output nsca_pkg::cand_t                    cand_s4
);

	localparam int DW = nsca_pkg::DATA_W;

	// stage 2: absolute coordinate differences
	nsca_pkg::tag_t   tag_s2;
	logic [DW-1:0]    adx_s2, ady_s2, rng_s2;
	logic             elig_s2;
	logic [DW:0]      dxa, dxb, dya, dyb;
	logic             x_ge, y_ge;

	// stage 3: squares
	nsca_pkg::tag_t               tag_s3;
	logic [nsca_pkg::SQ_W-1:0]    sqx_s3, sqy_s3, r2_s3;
	logic                         elig_s3;

	// stage 4: sum and compare
	logic                         valid_s4, last_s4, hit_s4;
	logic [nsca_pkg::SLOT_W-1:0]  slot_s4;
	logic [nsca_pkg::DIST_W-1:0]  sq_dist_s4;
	logic [nsca_pkg::DIST_W-1:0]  dist_sum;

	// both subtraction orders, pick the non-negative one (sign of the 17-bit diff)
	always_comb begin
		dxa  = {ent_s1.pos_x[DW-1], ent_s1.pos_x} - {node_x[DW-1], node_x};
		dxb  = {node_x[DW-1], node_x} - {ent_s1.pos_x[DW-1], ent_s1.pos_x};
		dya  = {ent_s1.pos_y[DW-1], ent_s1.pos_y} - {node_y[DW-1], node_y};
		dyb  = {node_y[DW-1], node_y} - {ent_s1.pos_y[DW-1], ent_s1.pos_y};
		x_ge = !dxa[DW];
		y_ge = !dya[DW];
	end

	assign dist_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	// pipeline valid/tag chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			tag_s3   <= '0;
			valid_s4 <= 1'b0;
			last_s4  <= 1'b0;
		end else begin
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			valid_s4 <= tag_s3.valid;
			last_s4  <= tag_s3.last;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		adx_s2  <= x_ge ? dxa[DW-1:0] : dxb[DW-1:0];
		ady_s2  <= y_ge ? dya[DW-1:0] : dyb[DW-1:0];
		rng_s2  <= ent_s1.rng;
		elig_s2 <= (load_s1 < ent_s1.lim);

		sqx_s3  <= adx_s2 * adx_s2;
		sqy_s3  <= ady_s2 * ady_s2;
		r2_s3   <= rng_s2 * rng_s2;
		elig_s3 <= elig_s2;

		slot_s4    <= tag_s3.slot;
		sq_dist_s4 <= dist_sum;
		hit_s4     <= elig_s3 && (dist_sum <= {1'b0, r2_s3});
	end

	assign cand_s4 = '{valid: valid_s4, last: last_s4, hit: hit_s4,
	                   slot: slot_s4, sq_dist: sq_dist_s4};

endmodule

// ===== rtl/nearest_station_capacity_assign_top.sv =====
// ----------------------------------------------------------------------------
// nearest_station_capacity_assign_top
// Station table with capacity-limited nearest station assignment.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low.
//   command = load writes station fields into table slot `slot` and clears
//   its load; busy stays low and no result is given.
//   command = assign sweeps slots 0..N-1, N = min(active_stations, 64),
//   reading one slot per cycle into a pipelined distance unit. The closest
//   eligible station (below capacity, within range, later slot on ties) has
//   its load bumped with saturation; with none eligible, slot 0 is used and
//   no_station_eligible is set.
//   An assign holds busy through the issue of the N slots on the single
//   table read port, the table read and pipeline drain, then the fetch and
//   update of the load counter; no new assign or load is taken until busy
//   falls.
//   The result is shown for one cycle with done high, the first cycle after
//   busy falls; the receiver cannot stall, so results are never held.
//   The user writes active_stations through cfg_wen/cfg_wdata only while
//   idle; the block does not enforce it. Reset clears control state and
//   active_stations; table contents are undefined until a slot is loaded.
// ----------------------------------------------------------------------------
module nearest_station_capacity_assign_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic [nsca_pkg::SLOT_W-1:0]        slot,
	input  logic [nsca_pkg::DATA_W-1:0]        node_id,
	input  logic signed [nsca_pkg::DATA_W-1:0] pos_x,
	input  logic signed [nsca_pkg::DATA_W-1:0] pos_y,
	input  logic [nsca_pkg::DATA_W-1:0]        cover_range,
	input  logic [nsca_pkg::DATA_W-1:0]        capacity,
	input  logic                               cfg_wen,
	input  logic [nsca_pkg::CNT_W-1:0]         cfg_wdata,
	output logic                               done,
	output logic [nsca_pkg::DATA_W-1:0]        assigned_node,
	output logic [nsca_pkg::DATA_W-1:0]        station_id,
	output logic [nsca_pkg::SLOT_W-1:0]        station_slot,
	output logic                               no_station_eligible
);

	localparam int SW = nsca_pkg::SLOT_W;
	localparam int CW = nsca_pkg::CNT_W;
	localparam int DW = nsca_pkg::DATA_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(nsca_pkg::MAX_STATIONS);
	localparam logic [DW-1:0] LOAD_SAT = '1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SWEEP  = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_FETCH  = 5'b01000,
		ST_UPDATE = 5'b10000
	} state_t;

	state_t state_q;

	// configuration and per-assign context
	logic [CW-1:0]        active_q;
	logic [CW-1:0]        count_q;
	logic [SW-1:0]        idx_q;
	logic [DW-1:0]        node_q;
	logic signed [DW-1:0] nx_q, ny_q;

	// best candidate tracking
	logic                          found_q;
	logic [SW-1:0]                 best_q;
	logic [nsca_pkg::DIST_W-1:0]   best_dist_q;

	// result registers
	logic          done_q;
	logic [DW-1:0] assigned_node_q, station_id_q;
	logic [SW-1:0] station_slot_q;
	logic          no_station_q;

	// table and distance unit wiring
	nsca_pkg::station_t wr_ent, rd_ent;
	logic [DW-1:0]      rd_load, ld_wr_data, load_inc;
	logic               accept, load_cmd, assign_cmd, upd_load;
	logic [SW-1:0]      rd_addr, ld_wr_addr;
	logic [CW-1:0]      count_next;
	logic               last_issue;
	nsca_pkg::tag_t     tag_s1;
	nsca_pkg::cand_t    cand_s4;
	logic               take_cand;

	// handshake decode
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign load_cmd   = accept && (command == nsca_pkg::CMD_LOAD);
	assign assign_cmd = accept && (command == nsca_pkg::CMD_ASSIGN);
	assign count_next = (active_q > MAX_CNT) ? MAX_CNT : active_q;
	assign last_issue = ({1'b0, idx_q} == (count_q - CW'(1)));

	// table write and read address selection
	assign wr_ent     = '{ident: node_id, pos_x: pos_x, pos_y: pos_y,
	                      rng: cover_range, lim: capacity};
	assign load_inc   = (rd_load == LOAD_SAT) ? rd_load : rd_load + DW'(1);
	assign upd_load   = (state_q == ST_UPDATE);
	assign ld_wr_addr = load_cmd ? slot : best_q;
	assign ld_wr_data = load_cmd ? '0 : load_inc;
	assign rd_addr    = (state_q == ST_SWEEP) ? idx_q : best_q;

	nsca_station_mem u_mem (
		.clk        (clk),
		.wr_en      (load_cmd),
		.wr_addr    (slot),
		.wr_ent     (wr_ent),
		.ld_wr_en   (load_cmd || upd_load),
		.ld_wr_addr (ld_wr_addr),
		.ld_wr_data (ld_wr_data),
		.rd_addr    (rd_addr),
		.rd_ent     (rd_ent),
		.rd_load    (rd_load)
	);

	nsca_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.ent_s1  (rd_ent),
		.load_s1 (rd_load),
		.node_x  (nx_q),
		.node_y  (ny_q),
		.cand_s4 (cand_s4)
	);

	// later slot wins on equal distance
	assign take_cand = cand_s4.valid && cand_s4.hit &&
	                   (!found_q || (cand_s4.sq_dist <= best_dist_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= '0;
			tag_s1   <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
			idx_q    <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			tag_s1 <= '0;
			if (cfg_wen) begin
				active_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (assign_cmd) begin
						count_q <= count_next;
						idx_q   <= '0;
						found_q <= 1'b0;
						best_q  <= '0;
						state_q <= (count_next == '0) ? ST_FETCH : ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					tag_s1 <= '{valid: 1'b1, last: last_issue, slot: idx_q};
					idx_q  <= idx_q + SW'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (take_cand) begin
						found_q <= 1'b1;
						best_q  <= cand_s4.slot;
					end
					if (cand_s4.valid && cand_s4.last) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// candidates can also land while the sweep is still issuing
			if (state_q == ST_SWEEP && take_cand) begin
				found_q <= 1'b1;
				best_q  <= cand_s4.slot;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (assign_cmd) begin
			node_q <= node_id;
			nx_q   <= pos_x;
			ny_q   <= pos_y;
		end
		if (take_cand) begin
			best_dist_q <= cand_s4.sq_dist;
		end
		if (upd_load) begin
			assigned_node_q <= node_q;
			station_id_q    <= rd_ent.ident;
			station_slot_q  <= best_q;
			no_station_q    <= !found_q;
		end
	end

	assign done                = done_q;
	assign assigned_node       = assigned_node_q;
	assign station_id          = station_id_q;
	assign station_slot        = station_slot_q;
	assign no_station_eligible = no_station_q;

	// a result always follows the load update step
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without load update");

	// candidates only arrive while an assign is sweeping or draining
	a_cand_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cand_s4.valid |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("distance unit output outside a sweep");

	// the fallback always reports slot 0
	a_fallback_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && no_station_q) |-> (station_slot_q == '0))
		else $error("fallback result not on slot 0");

	// no new item is taken while busy, so the node context holds
	a_ctx_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> $stable(node_q))
		else $error("node context changed during an assign");

endmodule
